// ===== design/tgd_pkg.sv =====
`default_nettype none

package tgd_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int TIME_WIDTH   = 32;
   localparam int LEVEL_WIDTH  = 15;
   localparam int DWELL_WIDTH  = 32;
   localparam int CODE_WIDTH   = 3;
   localparam int LED_COUNT    = 5;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // signed compare width: room for the sample, the level and its negation
   localparam int CMP_WIDTH =
      ((SAMPLE_WIDTH > LEVEL_WIDTH) ? SAMPLE_WIDTH : LEVEL_WIDTH) + 2;
   // elapsed time vs dwell compare width
   localparam int TCMP_WIDTH = (TIME_WIDTH > DWELL_WIDTH) ? TIME_WIDTH : DWELL_WIDTH;

   // animation time steps
   localparam int CLICK_SHIFT    = 16;
   localparam int PROPOSAL_SHIFT = 17;

   localparam logic [LEVEL_WIDTH-1:0] QUIET_RESET   = LEVEL_WIDTH'(50);
   localparam logic [LEVEL_WIDTH-1:0] GRAVITY_RESET = LEVEL_WIDTH'(100);
   localparam logic [DWELL_WIDTH-1:0] DWELL_RESET   = DWELL_WIDTH'(1) << 19;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUIET   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRAVITY = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DWELL   = 2'd2;

   localparam logic [CODE_WIDTH-1:0] EV_DOWN  = 3'd0;
   localparam logic [CODE_WIDTH-1:0] EV_LEFT  = 3'd1;
   localparam logic [CODE_WIDTH-1:0] EV_RIGHT = 3'd2;
   localparam logic [CODE_WIDTH-1:0] EV_ENTER = 3'd3;
   localparam logic [CODE_WIDTH-1:0] EV_EXIT  = 3'd4;
   localparam logic [CODE_WIDTH-1:0] EV_NONE  = 3'd0;

   localparam logic [LED_COUNT-1:0] LED_OFF  = 5'h00;
   localparam logic [LED_COUNT-1:0] LED_FULL = 5'h1f;

   typedef enum logic [5:0] {
      ORI_DOWN    = 6'b000001,
      ORI_LEFT    = 6'b000010,
      ORI_RIGHT   = 6'b000100,
      ORI_UP      = 6'b001000,
      ORI_NEUTRAL = 6'b010000,
      ORI_UNDEF   = 6'b100000
   } ori_type;

   typedef enum logic [1:0] {
      ANIM_BLACK    = 2'd0,
      ANIM_CLICK    = 2'd1,
      ANIM_PROPOSAL = 2'd2
   } anim_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] accel_x;
      logic signed [SAMPLE_WIDTH-1:0] accel_y;
      logic signed [SAMPLE_WIDTH-1:0] accel_z;
      logic        [TIME_WIDTH-1:0]   now_us;
   } req_type;

   typedef struct packed {
      logic                  event_valid;
      logic [CODE_WIDTH-1:0] event_code;
      logic                  led_enable;
      logic [LED_COUNT-1:0]  led_bits;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] quiet_band;
      logic [LEVEL_WIDTH-1:0] gravity_level;
      logic [DWELL_WIDTH-1:0] dwell_us;
   } cfg_type;

   function automatic logic [CODE_WIDTH-1:0] ori_code(input ori_type ori);
      logic [CODE_WIDTH-1:0] code;
      case (ori)
         ORI_DOWN:    code = EV_DOWN;
         ORI_LEFT:    code = EV_LEFT;
         ORI_RIGHT:   code = EV_RIGHT;
         ORI_UP:      code = EV_ENTER;
         ORI_NEUTRAL: code = EV_EXIT;
         default:     code = EV_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [LED_COUNT-1:0] click_frame(input logic [1:0] idx);
      logic [LED_COUNT-1:0] f;
      case (idx)
         2'd0:    f = 5'h04;
         2'd1:    f = 5'h0e;
         2'd2:    f = 5'h0e;
         default: f = 5'h1f;
      endcase
      return f;
   endfunction

   function automatic logic [LED_COUNT-1:0] proposal_frame(input logic [1:0] idx);
      logic [LED_COUNT-1:0] f;
      case (idx)
         2'd0:    f = 5'h10;
         2'd1:    f = 5'h18;
         2'd2:    f = 5'h1c;
         default: f = 5'h1e;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== design/tilt_gesture_dwell_fsm.sv =====
// Tilt gesture recognizer with dwell confirmation and LED animation frame.
// Path: a beat is captured in the input register, then stepped into the result register unless rsp stalls.
// Throughput: one beat per cycle while rsp is not stalled; input register -> classify/state step -> result register.
// Backpressure on rsp stalls req only when both registers are full.
// Reset (synchronous, active high): orientation undefined, nothing pending,
// black animation, registers back to quiet 50, gravity 100, dwell 2^19 us.
`default_nettype none

module tilt_gesture_dwell_fsm (
   input  var logic                                   clock,
   input  var logic                                   reset,
   // sample channel
   input  var logic                                   req_valid,
   output logic                                       req_stall,
   input  var tgd_pkg::req_type                       req_data,
   // result channel
   output logic                                       rsp_valid,
   input  var logic                                   rsp_stall,
   output tgd_pkg::rsp_type                           rsp_data,
   // register writes
   input  var logic                                   csr_valid,
   output logic                                       csr_ready,
   input  var logic [tgd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  var logic [tgd_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // input register
   logic             s1_valid_ff, s1_valid_in;
   tgd_pkg::req_type s1_data_ff;
   // result register
   logic             out_valid_ff, out_valid_in;
   tgd_pkg::rsp_type out_data_ff;
   tgd_pkg::rsp_type step_result;
   // configuration
   tgd_pkg::cfg_type cfg_ff;

   logic out_can;   // result register free this cycle
   logic fire;      // input beat moves into the result register
   logic req_take;

   assign out_can   = !out_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_can;
   assign req_stall = s1_valid_ff && !out_can;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (out_can ? 1'b0 : out_valid_ff);

   // state lives in the core and advances only when a beat commits
   tgd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .sample (s1_data_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= step_result;
      end
   end

   // config writes are taken whenever offered; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quiet_band    <= tgd_pkg::QUIET_RESET;
         cfg_ff.gravity_level <= tgd_pkg::GRAVITY_RESET;
         cfg_ff.dwell_us      <= tgd_pkg::DWELL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tgd_pkg::CSR_QUIET:
               cfg_ff.quiet_band <= csr_wdata[tgd_pkg::LEVEL_WIDTH-1:0];
            tgd_pkg::CSR_GRAVITY:
               cfg_ff.gravity_level <= csr_wdata[tgd_pkg::LEVEL_WIDTH-1:0];
            tgd_pkg::CSR_DWELL:
               cfg_ff.dwell_us <= csr_wdata[tgd_pkg::DWELL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTH
   // stall toward the sender only with a beat held in the input register
   a_stall_has_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall without a held beat");

   // a confirmed enter leaves the block in up, so the LEDs go dark
   a_enter_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_valid && (rsp_data.event_code == tgd_pkg::EV_ENTER)
      |-> !rsp_data.led_enable)
      else $error("enter event with LEDs enabled");

   // no event means code zero; dark means no LEDs lit
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.event_valid || (rsp_data.event_code == tgd_pkg::EV_NONE))
                  && (rsp_data.led_enable || (rsp_data.led_bits == tgd_pkg::LED_OFF))))
      else $error("stray result fields");

   // a committed beat shows up as a result on the next cycle
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("committed beat lost");
`endif

endmodule

`default_nettype wire

// ===== design/tgd_classify.sv =====
`default_nettype none

module tgd_classify (
   input  var tgd_pkg::req_type sample,
   input  var tgd_pkg::cfg_type cfg,
   output tgd_pkg::ori_type     cls
);

   localparam int SW = tgd_pkg::SAMPLE_WIDTH;
   localparam int CW = tgd_pkg::CMP_WIDTH;
   localparam int LW = tgd_pkg::LEVEL_WIDTH;

   logic signed [CW-1:0] x, y, z, q, g;
   logic qx, qy, qz;

   assign x = {{(CW-SW){sample.accel_x[SW-1]}}, sample.accel_x};
   assign y = {{(CW-SW){sample.accel_y[SW-1]}}, sample.accel_y};
   assign z = {{(CW-SW){sample.accel_z[SW-1]}}, sample.accel_z};
   assign q = {{(CW-LW){1'b0}}, cfg.quiet_band};
   assign g = {{(CW-LW){1'b0}}, cfg.gravity_level};

   // strictly inside the quiet band
   assign qx = (x > -q) && (x < q);
   assign qy = (y > -q) && (y < q);
   assign qz = (z > -q) && (z < q);

   always_comb begin
      if (qx && qy && (z > g)) begin
         cls = tgd_pkg::ORI_NEUTRAL;
      end else if (qx && qz && (y < -g)) begin
         cls = tgd_pkg::ORI_UP;
      end else if (qx && qz && (y > g)) begin
         cls = tgd_pkg::ORI_DOWN;
      end else if (qy && qz && (x < -g)) begin
         cls = tgd_pkg::ORI_LEFT;
      end else if (qy && qz && (x > g)) begin
         cls = tgd_pkg::ORI_RIGHT;
      end else begin
         cls = tgd_pkg::ORI_UNDEF;
      end
   end

endmodule

`default_nettype wire

// ===== design/tgd_core.sv =====
`default_nettype none

module tgd_core (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             fire,
   input  var tgd_pkg::req_type sample,
   input  var tgd_pkg::cfg_type cfg,
   output tgd_pkg::rsp_type     result
);

   localparam int TW  = tgd_pkg::TIME_WIDTH;
   localparam int TCW = tgd_pkg::TCMP_WIDTH;
   localparam int CS  = tgd_pkg::CLICK_SHIFT;
   localparam int PS  = tgd_pkg::PROPOSAL_SHIFT;

   tgd_pkg::ori_type  ori_ff, ori_in, cls;
   tgd_pkg::anim_type anim_ff, anim_in;
   logic              pend_ff, pend_in;
   logic [TW-1:0]     since_ff, since_in;
   logic [TW-1:0]     astart_ff, astart_in;
   logic [TW-1:0]     elapsed, d;
   logic              dwell_done;
   logic              ev_valid;
   logic [tgd_pkg::CODE_WIDTH-1:0] ev_code;
   logic [tgd_pkg::LED_COUNT-1:0]  led;
   logic              led_en;

   tgd_classify u_classify (
      .sample (sample),
      .cfg    (cfg),
      .cls    (cls)
   );

   assign elapsed    = sample.now_us - since_ff;
   assign dwell_done = TCW'(elapsed) > TCW'(cfg.dwell_us);

   always_comb begin
      ori_in    = ori_ff;
      pend_in   = pend_ff;
      since_in  = since_ff;
      anim_in   = anim_ff;
      astart_in = astart_ff;
      ev_valid  = 1'b0;
      ev_code   = tgd_pkg::EV_NONE;
      if (pend_ff) begin
         if (ori_ff == cls) begin
            if (dwell_done) begin
               pend_in   = 1'b0;
               ev_valid  = 1'b1;
               ev_code   = tgd_pkg::ori_code(cls);
               anim_in   = tgd_pkg::ANIM_CLICK;
               astart_in = sample.now_us;
            end
         end else begin
            // abandoned proposal falls back
            ori_in    = (ori_ff == tgd_pkg::ORI_NEUTRAL) ? tgd_pkg::ORI_UP
                                                         : tgd_pkg::ORI_NEUTRAL;
            pend_in   = 1'b0;
            anim_in   = tgd_pkg::ANIM_BLACK;
            astart_in = sample.now_us;
         end
      end else begin
         case (ori_ff)
            tgd_pkg::ORI_UP: begin
               if (cls == tgd_pkg::ORI_NEUTRAL) begin
                  ori_in    = cls;
                  pend_in   = 1'b1;
                  since_in  = sample.now_us;
                  anim_in   = tgd_pkg::ANIM_PROPOSAL;
                  astart_in = sample.now_us;
               end
            end
            tgd_pkg::ORI_NEUTRAL: begin
               if (cls inside {tgd_pkg::ORI_DOWN, tgd_pkg::ORI_LEFT,
                               tgd_pkg::ORI_RIGHT, tgd_pkg::ORI_UP}) begin
                  ori_in    = cls;
                  pend_in   = 1'b1;
                  since_in  = sample.now_us;
                  anim_in   = tgd_pkg::ANIM_PROPOSAL;
                  astart_in = sample.now_us;
               end
            end
            default: begin
               if (cls == tgd_pkg::ORI_NEUTRAL) begin
                  ori_in = tgd_pkg::ORI_NEUTRAL;
               end
            end
         endcase
      end
   end

   // LED frame from the updated state
   assign d      = sample.now_us - astart_in;
   assign led_en = pend_in || (ori_in != tgd_pkg::ORI_UP);

   always_comb begin
      led = tgd_pkg::LED_OFF;
      if (led_en) begin
         case (anim_in)
            tgd_pkg::ANIM_CLICK: begin
               led = (d[TW-1:CS+2] == '0) ? tgd_pkg::click_frame(d[CS+1:CS])
                                          : tgd_pkg::LED_OFF;
            end
            tgd_pkg::ANIM_PROPOSAL: begin
               led = (d[TW-1:PS+2] == '0) ? tgd_pkg::proposal_frame(d[PS+1:PS])
                                          : tgd_pkg::LED_FULL;
            end
            default: led = tgd_pkg::LED_OFF;
         endcase
      end
   end

   assign result.event_valid = ev_valid;
   assign result.event_code  = ev_code;
   assign result.led_enable  = led_en;
   assign result.led_bits    = led;

   always_ff @(posedge clock) begin
      if (reset) begin
         ori_ff    <= tgd_pkg::ORI_UNDEF;
         pend_ff   <= 1'b0;
         since_ff  <= '0;
         anim_ff   <= tgd_pkg::ANIM_BLACK;
         astart_ff <= '0;
      end else if (fire) begin
         ori_ff    <= ori_in;
         pend_ff   <= pend_in;
         since_ff  <= since_in;
         anim_ff   <= anim_in;
         astart_ff <= astart_in;
      end
   end

endmodule

`default_nettype wire
